[design/base64_stream_encoder_top_macros.svh]
// assertion macros shared by the base64 encoder checker
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define B64E_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/b64e_pkg.sv]
// shared types, constants and the alphabet mapping of the base64 encoder
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // one classified byte: up to four output slots
   typedef struct packed {
      logic [3:0][5:0] sext;
      logic [3:0]      pad;
      logic [1:0]      last_idx;
      logic            fin;
   } job_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         return w + 8'h41;           // 'A'..'Z'
      end else if (v < 6'd52) begin
         return w + 8'h47;           // 'a'..'z'
      end else if (v < 6'd62) begin
         return w - 8'h04;           // '0'..'9'
      end else if (v == 6'd62) begin
         return 8'h2B;               // '+'
      end else begin
         return 8'h2F;               // '/'
      end
   endfunction

endpackage

[design/base64_stream_encoder_top.sv]
// base64 stream encoder: message bytes in, alphabet characters out
//
// request channel (req_): one message byte per request in tdata, tlast set
// on the final byte of a message.
// response channel (rsp_): one ASCII character per transfer in tdata; tlast
// marks the last character caused by a request byte, tuser marks the last
// character of the whole encoded message.
// a byte at the first or second place of a three-byte group gives one
// character, the third gives two; a final byte at the first or second place
// adds the flush character and '=' padding, up to four characters in all.
// the first character of a byte passes through the job queue and then the
// character register before it is valid. the back end sends one character
// per cycle while the receiver does not stall; the output register is the
// pacing unit.
// reset clears the group position, empties the job queue and drops rsp_tvalid.
// when the receiver stalls the character register holds, the job queue
// (QUEUE_DEPTH jobs) absorbs bytes, and then req_tready goes low.
module base64_stream_encoder_top #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   output logic [0:0] rsp_tuser    // [0] message_end
);

   b64e_pkg::job_type push_job, pop_job;
   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job        (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[design/b64e_front.sv]
// front end: takes bytes, tracks the group position and builds output jobs
module b64e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   output logic              push_valid,
   input  logic              push_ready,
   output b64e_pkg::job_type push_job
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          carry_ff, carry_in;
   logic                accept;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && push_ready;
   assign push_valid = req_tvalid;

   // next group position and leftover bits
   always_comb begin
      phase_in = phase_ff;
      carry_in = carry_ff;
      if (accept) begin
         unique case (phase_ff)
            b64e_pkg::PH_SECOND: begin
               phase_in = b64e_pkg::PH_THIRD;
               carry_in = req_tdata[3:0];
            end
            b64e_pkg::PH_THIRD: begin
               phase_in = b64e_pkg::PH_FIRST;
               carry_in = 4'd0;
            end
            default: begin
               phase_in = b64e_pkg::PH_SECOND;
               carry_in = {2'b00, req_tdata[1:0]};
            end
         endcase
         if (req_tlast) begin
            phase_in = b64e_pkg::PH_FIRST;
            carry_in = 4'd0;
         end
      end
   end

   // job contents for the current byte
   always_comb begin
      push_job     = '0;
      push_job.fin = req_tlast;
      unique case (phase_ff)
         b64e_pkg::PH_SECOND: begin
            push_job.sext[0] = {carry_ff[1:0], req_tdata[7:4]};
            if (req_tlast) begin
               push_job.sext[1]  = {req_tdata[3:0], 2'b00};
               push_job.pad[2]   = 1'b1;
               push_job.last_idx = 2'd2;
            end
         end
         b64e_pkg::PH_THIRD: begin
            push_job.sext[0]  = {carry_ff, req_tdata[7:6]};
            push_job.sext[1]  = req_tdata[5:0];
            push_job.last_idx = 2'd1;
         end
         default: begin
            push_job.sext[0] = req_tdata[7:2];
            if (req_tlast) begin
               push_job.sext[1]  = {req_tdata[1:0], 4'b0000};
               push_job.pad[2]   = 1'b1;
               push_job.pad[3]   = 1'b1;
               push_job.last_idx = 2'd3;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PH_FIRST;
         carry_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

[design/b64e_queue.sv]
// short job queue between front and back end
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  b64e_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output b64e_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64e_pkg::job_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/b64e_back.sv]
// back end: walks the slots of each job and drives the character register
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  b64e_pkg::job_type job,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic [0:0]        rsp_tuser
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       end_ff, end_in;
   logic       out_free, load, at_last;

   assign out_free  = !valid_ff || rsp_tready;
   assign load      = job_valid && out_free;
   assign at_last   = (idx_ff == job.last_idx);
   assign job_ready = load && at_last;

   always_comb begin
      char_in  = job.pad[idx_ff] ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(job.sext[idx_ff]);
      last_in  = at_last;
      end_in   = at_last && job.fin;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
         end_ff  <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = char_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = end_ff;

endmodule

[design/b64e_checker.sv]
// port-level checks for the base64 encoder and their binding
`include "base64_stream_encoder_top_macros.svh"

module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);

   logic rsp_hold;
   logic pad_run_end;

   assign rsp_hold    = rsp_tvalid && !rsp_tready;
   assign pad_run_end = rsp_tvalid && rsp_tlast && (rsp_tdata == b64e_pkg::PAD_CHAR);

   // a stalled response keeps its character and flags
   `B64E_ASSERT(a_rsp_hold, rsp_hold |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled response changed")

   // message end is always the last character of its request
   `B64E_ASSERT(a_end_in_run, rsp_tvalid && rsp_tuser[0] |-> rsp_tlast, "message end without run end")

   // padding closing a run can only close the message
   `B64E_ASSERT(a_pad_at_end, pad_run_end |-> rsp_tuser[0], "padding outside message end")

   // no response straight after reset
   `B64E_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[tb/tb_base64_stream_encoder_top.sv]
// self-checking testbench for the base64 stream encoder
`timescale 1ns / 100ps

module tb_base64_stream_encoder_top;

   localparam int HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PER_PHASE = 24;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } msg_byte_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       run_end;
      logic       msg_end;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [0:0] rsp_tuser;

   msg_byte_type byte_queue[$];
   enc_char_type char_queue[$];
   msg_byte_type next_byte;

   string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // predictor state
   b64e_pkg::phase_type enc_phase = b64e_pkg::PH_FIRST;
   logic [3:0]          enc_carry = 4'h0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int idle_cycles = 0;
   int errors = 0;

   base64_stream_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      return b64_alphabet[v];
   endfunction

   task automatic report(input string msg);
      $display("error: %s", msg);
      errors++;
   endtask

   // expected characters of one accepted byte
   task automatic encode_byte(input logic [7:0] b, input logic fin);
      logic [7:0] chars[4];
      int n;
      n = 0;
      case (enc_phase)
         b64e_pkg::PH_SECOND: begin
            chars[n++] = b64_char({enc_carry[1:0], b[7:4]});
            if (fin) begin
               chars[n++] = b64_char({b[3:0], 2'b00});
               chars[n++] = b64e_pkg::PAD_CHAR;
            end
            enc_carry = b[3:0];
            enc_phase = b64e_pkg::PH_THIRD;
         end
         b64e_pkg::PH_THIRD: begin
            chars[n++] = b64_char({enc_carry, b[7:6]});
            chars[n++] = b64_char(b[5:0]);
            enc_carry = 4'h0;
            enc_phase = b64e_pkg::PH_FIRST;
         end
         default: begin
            chars[n++] = b64_char(b[7:2]);
            if (fin) begin
               chars[n++] = b64_char({b[1:0], 4'h0});
               chars[n++] = b64e_pkg::PAD_CHAR;
               chars[n++] = b64e_pkg::PAD_CHAR;
            end
            enc_carry = {2'b00, b[1:0]};
            enc_phase = b64e_pkg::PH_SECOND;
         end
      endcase
      if (fin) begin
         enc_phase = b64e_pkg::PH_FIRST;
         enc_carry = 4'h0;
      end
      for (int i = 0; i < n; i++) begin
         char_queue.push_back('{ch: chars[i], run_end: (i == n - 1),
                                msg_end: fin && (i == n - 1)});
      end
   endtask

   task automatic add_message(input int len, input bit terminated);
      logic [7:0] d;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0: d = 8'h00;
            1: d = 8'hFF;
            default: d = 8'($urandom_range(0, 255));
         endcase
         byte_queue.push_back('{data: d, last: terminated && (i == len - 1)});
      end
   endtask

   task automatic add_fixed(input logic [7:0] d, input logic fin);
      byte_queue.push_back('{data: d, last: fin});
   endtask

   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_tvalid || char_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic add_random_part();
      int count;
      int len;
      count = 0;
      while (count < RANDOM_PER_PHASE) begin
         if ($urandom_range(0, 9) == 0) begin
            // long unterminated stretch running through many groups
            len = $urandom_range(8, 16);
            add_message(len, 1'b0);
         end else begin
            len = $urandom_range(1, 7);
            add_message(len, 1'b1);
         end
         count += len;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_byte = byte_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_byte.data;
               req_tlast  <= next_byte.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor and receiver back-pressure
   always @(posedge clock) begin
      enc_char_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (char_queue.size() == 0) begin
               report($sformatf("unexpected character 0x%02h", rsp_tdata));
            end else begin
               want = char_queue.pop_front();
               if (rsp_tdata !== want.ch)
                  report($sformatf("char 0x%02h, want 0x%02h", rsp_tdata, want.ch));
               if (rsp_tlast !== want.run_end)
                  report($sformatf("tlast %b, want %b on char 0x%02h",
                                   rsp_tlast, want.run_end, want.ch));
               if (rsp_tuser[0] !== want.msg_end)
                  report($sformatf("tuser %b, want %b on char 0x%02h",
                                   rsp_tuser[0], want.msg_end, want.ch));
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("base64_stream_encoder_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 74, 0, 29};
      recv_pct = '{0, 0, 74, 29};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed messages: extremes, every pad length, full group on the final byte
      add_fixed(8'h00, 1'b1);
      add_fixed(8'hFF, 1'b1);
      add_fixed(8'hFF, 1'b0); add_fixed(8'hFF, 1'b1);
      add_fixed(8'h00, 1'b0); add_fixed(8'h00, 1'b0); add_fixed(8'h00, 1'b1);
      add_fixed(8'hFB, 1'b0); add_fixed(8'hEF, 1'b0); add_fixed(8'hBE, 1'b1);
      add_fixed(8'h80, 1'b0); add_fixed(8'h01, 1'b0); add_fixed(8'h7F, 1'b0);
      add_fixed(8'hFE, 1'b1);
      add_fixed(8'h4D, 1'b0); add_fixed(8'h61, 1'b0); add_fixed(8'h6E, 1'b0);
      add_fixed(8'h12, 1'b0); add_fixed(8'h34, 1'b1);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         // long receiver hold-off while the sender keeps offering bytes
         if (p == 0) hold_token++;
         add_random_part();
         // sender pauses here until every character has come back
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (char_queue.size() != 0)
         report($sformatf("%0d characters never arrived", char_queue.size()));
      if (errors == 0) begin
         $display("base64_stream_encoder_top: match");
      end else begin
         $display("base64_stream_encoder_top: mismatch");
      end
      $finish;
   end

endmodule
